### rtl/tbt_pkg.sv
// ----------------------------------------------------------------------------
// tbt_pkg
// shared types, constants and saturation helpers of the tensor basis transfer
// ----------------------------------------------------------------------------
package tbt_pkg;

   localparam int MAX_POINTS_AXIS = 4;
   localparam int MAX_DOFS_AXIS   = 4;
   localparam int AXIS_LIMIT      = 4;
   localparam int COORD_W         = 2;
   localparam int GRID_DEPTH      = 64;
   localparam int ADDR_W          = 6;
   localparam int VALUE_W         = 32;
   localparam int COEF_W          = 32;
   localparam int ACC_W           = 48;
   localparam int MAC_LATENCY     = 4;

   localparam logic [1:0] OP_COEF  = 2'd0;
   localparam logic [1:0] OP_MASK  = 2'd1;
   localparam logic [1:0] OP_VALUE = 2'd2;

   localparam logic [1:0] CSR_DIMENSION = 2'd0;
   localparam logic [1:0] CSR_DIRECTION = 2'd1;
   localparam logic [1:0] CSR_DOFS      = 2'd2;
   localparam logic [1:0] CSR_POINTS    = 2'd3;

   localparam logic [1:0] PASS_X = 2'd0;
   localparam logic [1:0] PASS_Y = 2'd1;
   localparam logic [1:0] PASS_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // tag travelling with one multiply-accumulate
   typedef struct packed {
      logic              valid;
      logic              wr;
      logic              to_buf1;
      logic [ADDR_W-1:0] addr;
   } tag_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+3:0] x);
      logic signed [ACC_W-1:0] r;
      if ((&x[ACC_W+3:ACC_W-1]) || (~|x[ACC_W+3:ACC_W-1])) r = x[ACC_W-1:0];
      else if (x[ACC_W+3]) r = {1'b1, {(ACC_W-1){1'b0}}};
      else r = {1'b0, {(ACC_W-1){1'b1}}};
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] sat_out(input logic signed [ACC_W-1:0] x);
      logic signed [VALUE_W-1:0] r;
      if ((&x[ACC_W-1:VALUE_W-1]) || (~|x[ACC_W-1:VALUE_W-1])) r = x[VALUE_W-1:0];
      else if (x[ACC_W-1]) r = {1'b1, {(VALUE_W-1){1'b0}}};
      else r = {1'b0, {(VALUE_W-1){1'b1}}};
      return r;
   endfunction

endpackage

### rtl/tbt_ram.sv
// ----------------------------------------------------------------------------
// tbt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/tbt_cell.sv
// ----------------------------------------------------------------------------
// tbt_cell
// one accumulator cell of the recirculating ring
// ----------------------------------------------------------------------------
module tbt_cell (
   input  logic                             clock,
   input  logic signed [tbt_pkg::ACC_W-1:0] acc_in,
   output logic signed [tbt_pkg::ACC_W-1:0] acc_out
);

   logic signed [tbt_pkg::ACC_W-1:0] acc_ff;

   // hands its partial sum to the next cell every cycle
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_out = acc_ff;

endmodule

### rtl/tbt_mac.sv
// ----------------------------------------------------------------------------
// tbt_mac
// four stage multiply-accumulate: q30 rounded product, saturated 48-bit sum
// ----------------------------------------------------------------------------
module tbt_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  tbt_pkg::tag_type                  tag_in,
   input  logic signed [tbt_pkg::ACC_W-1:0]  acc_in,
   input  logic signed [tbt_pkg::ACC_W-1:0]  a_in,
   input  logic signed [tbt_pkg::COEF_W-1:0] c_in,
   output tbt_pkg::tag_type                  tag_out,
   output logic signed [tbt_pkg::ACC_W-1:0]  sum_out
);

   tbt_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic signed [tbt_pkg::ACC_W-1:0]  acc1_ff, acc2_ff, acc3_ff, sum_ff;
   logic signed [tbt_pkg::ACC_W-1:0]  a1_ff;
   logic signed [tbt_pkg::COEF_W-1:0] c1_ff;
   logic signed [55:0] hi_in, hi_ff;
   logic signed [56:0] lo_in, lo_ff;
   logic signed [80:0] full_in;
   logic signed [50:0] term_ff;
   logic signed [tbt_pkg::ACC_W+3:0] sum_wide;

   // split the 48-bit operand so each product stays near 32 by 32
   assign hi_in = 56'($signed(a1_ff[47:24])) * 56'(c1_ff);
   assign lo_in = 57'($signed({1'b0, a1_ff[23:0]})) * 57'(c1_ff);

   // round half up at bit 30, floor shift
   assign full_in = $signed({hi_ff[55], hi_ff, 24'd0}) + $signed({{24{lo_ff[56]}}, lo_ff})
                  + $signed(81'(1) <<< 29);

   assign sum_wide = $signed({{4{acc3_ff[tbt_pkg::ACC_W-1]}}, acc3_ff})
                   + $signed({term_ff[50], term_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc1_ff <= acc_in;
      a1_ff   <= a_in;
      c1_ff   <= c_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      acc2_ff <= acc1_ff;
      term_ff <= full_in[80:30];
      acc3_ff <= acc2_ff;
      sum_ff  <= tbt_pkg::sat_acc(sum_wide);
   end

   assign tag_out = tag4_ff;
   assign sum_out = sum_ff;

endmodule

### rtl/tensor_basis_transfer.sv
// ----------------------------------------------------------------------------
// tensor_basis_transfer
// sum-factorised 1d basis transfer over 2d or 3d tensor-product elements
// ----------------------------------------------------------------------------
// a request with start high is taken whenever busy is low. a value request
// marked last starts the transform: one pass per axis (x, then y, then z in
// 3d), each output line built in a ring of accumulator cells that circulates
// through one pipelined multiply-accumulate. every input index of a line
// costs one ring revolution whatever the configured sizes. the results then
// follow at one per cycle; they appear for exactly one cycle with rsp_valid
// and cannot be held off; busy drops in the cycle that presents the last
// result.
// ----------------------------------------------------------------------------
module tensor_basis_transfer #(
   parameter int MAX_POINTS_AXIS = tbt_pkg::MAX_POINTS_AXIS,
   parameter int MAX_DOFS_AXIS   = tbt_pkg::MAX_DOFS_AXIS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_op,
   input  logic [tbt_pkg::ADDR_W-1:0]         req_index,
   input  logic signed [tbt_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_mask_bit,
   input  logic                               req_last,
   // result channel
   output logic                               rsp_valid,
   output logic [tbt_pkg::ADDR_W-1:0]         rsp_out_index,
   output logic signed [tbt_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                               rsp_out_last,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [2:0]                         csr_data
);

   localparam int AX          = (MAX_POINTS_AXIS > MAX_DOFS_AXIS) ?
                                MAX_POINTS_AXIS : MAX_DOFS_AXIS;
   localparam int NCELL       = AX + 1;
   localparam int REV_LEN     = NCELL + tbt_pkg::MAC_LATENCY;
   localparam int SLOT_W      = $clog2(REV_LEN);
   localparam int BASIS_DEPTH = MAX_POINTS_AXIS * MAX_DOFS_AXIS;
   localparam int BASIS_W     = (BASIS_DEPTH > 1) ? $clog2(BASIS_DEPTH) : 1;
   localparam int AW          = tbt_pkg::ADDR_W;
   localparam int CW          = tbt_pkg::COORD_W;
   localparam int ACCW        = tbt_pkg::ACC_W;

   // ---------------- configuration registers ----------------
   logic [1:0] dim_ff;
   logic       dir_ff;
   logic [2:0] dofs_ff, pts_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff  <= 2'd2;
         dir_ff  <= 1'b0;
         dofs_ff <= 3'd2;
         pts_ff  <= 3'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbt_pkg::CSR_DIMENSION: dim_ff  <= csr_data[1:0];
            tbt_pkg::CSR_DIRECTION: dir_ff  <= csr_data[0];
            tbt_pkg::CSR_DOFS:      dofs_ff <= csr_data;
            tbt_pkg::CSR_POINTS:    pts_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // axis sizes, clamped to 1..max
   logic [2:0] d_cl, q_cl, nin, nout, nzi, nzo;
   logic       three, restr;
   logic [CW-1:0] nin_m1, nout_m1, nzi_m1, nzo_m1;

   always_comb begin
      if (dofs_ff == 3'd0) d_cl = 3'd1;
      else if (dofs_ff > 3'(MAX_DOFS_AXIS)) d_cl = 3'(MAX_DOFS_AXIS);
      else d_cl = dofs_ff;
      if (pts_ff == 3'd0) q_cl = 3'd1;
      else if (pts_ff > 3'(MAX_POINTS_AXIS)) q_cl = 3'(MAX_POINTS_AXIS);
      else q_cl = pts_ff;
   end

   assign three   = (dim_ff == 2'd3);
   assign restr   = dir_ff;
   assign nin     = restr ? q_cl : d_cl;
   assign nout    = restr ? d_cl : q_cl;
   assign nzi     = three ? nin : 3'd1;
   assign nzo     = three ? nout : 3'd1;
   assign nin_m1  = CW'(nin - 3'd1);
   assign nout_m1 = CW'(nout - 3'd1);
   assign nzi_m1  = CW'(nzi - 3'd1);
   assign nzo_m1  = CW'(nzo - 3'd1);

   // ---------------- sequencer state ----------------
   tbt_pkg::state_type state_ff, state_in;
   logic [1:0]        pass_ff, pass_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CW-1:0]     i_ff, i_in, u_ff, u_in, v_ff, v_in;
   logic [CW-1:0]     ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in;
   logic [AW-1:0]     k_ff, k_in;
   logic              accept;
   logic              em_last;

   assign accept = start && !busy;

   // loop bounds of the current pass
   logic [CW-1:0] i_lim, u_lim, v_lim;

   always_comb begin
      case (pass_ff)
         tbt_pkg::PASS_X: begin
            i_lim = nin_m1;  u_lim = nin_m1;  v_lim = nzi_m1;
         end
         tbt_pkg::PASS_Y: begin
            i_lim = nin_m1;  u_lim = nout_m1; v_lim = nzi_m1;
         end
         default: begin
            i_lim = nin_m1;  u_lim = nout_m1; v_lim = nout_m1;
         end
      endcase
   end

   assign em_last = (ex_ff == nout_m1) && (ey_ff == nout_m1) && (ez_ff == nzo_m1);

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      slot_in  = slot_ff;
      i_in     = i_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      ez_in    = ez_ff;
      k_in     = k_ff;
      case (state_ff)
         tbt_pkg::ST_IDLE: begin
            if (accept && req_op == tbt_pkg::OP_VALUE && req_last) begin
               state_in = tbt_pkg::ST_RUN;
               pass_in  = tbt_pkg::PASS_X;
               slot_in  = '0;
               i_in     = '0;
               u_in     = '0;
               v_in     = '0;
            end
         end
         tbt_pkg::ST_RUN: begin
            if (slot_ff == SLOT_W'(REV_LEN - 1)) begin
               // end of a revolution: next input index, line, plane, pass
               slot_in = '0;
               if (i_ff != i_lim) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  i_in = '0;
                  if (u_ff != u_lim) begin
                     u_in = u_ff + 1'b1;
                  end else begin
                     u_in = '0;
                     if (v_ff != v_lim) begin
                        v_in = v_ff + 1'b1;
                     end else begin
                        v_in = '0;
                        if (pass_ff == tbt_pkg::PASS_X) begin
                           pass_in = tbt_pkg::PASS_Y;
                        end else if (pass_ff == tbt_pkg::PASS_Y && three) begin
                           pass_in = tbt_pkg::PASS_Z;
                        end else begin
                           state_in = tbt_pkg::ST_EMIT;
                           ex_in    = '0;
                           ey_in    = '0;
                           ez_in    = '0;
                           k_in     = '0;
                        end
                     end
                  end
               end
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         tbt_pkg::ST_EMIT: begin
            k_in = k_ff + 1'b1;
            if (em_last) begin
               state_in = tbt_pkg::ST_IDLE;
            end else if (ex_ff != nout_m1) begin
               ex_in = ex_ff + 1'b1;
            end else begin
               ex_in = '0;
               if (ey_ff != nout_m1) begin
                  ey_in = ey_ff + 1'b1;
               end else begin
                  ey_in = '0;
                  ez_in = ez_ff + 1'b1;
               end
            end
         end
         default: state_in = tbt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbt_pkg::ST_IDLE;
         pass_ff  <= tbt_pkg::PASS_X;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      u_ff  <= u_in;
      v_ff  <= v_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      ez_ff <= ez_in;
      k_ff  <= k_in;
   end

   // ---------------- basis coefficients ----------------
   logic signed [tbt_pkg::COEF_W-1:0] basis_ff [BASIS_DEPTH];

   always_ff @(posedge clock) begin
      if (accept && req_op == tbt_pkg::OP_COEF && 7'(req_index) < 7'(BASIS_DEPTH)) begin
         basis_ff[BASIS_W'(req_index)] <= req_value;
      end
   end

   // ---------------- stores ----------------
   logic [AW-1:0] pos, emit_addr, mask_raddr, buf0_raddr, buf1_raddr;
   logic [tbt_pkg::VALUE_W-1:0] elem_rd;
   logic                        mask_rd;
   logic [ACCW-1:0]             buf0_rd, buf1_rd;
   tbt_pkg::tag_type            tag_issue, tag_done;
   logic signed [ACCW-1:0]      mac_sum;

   // lexicographic position of an element value, wraps at the grid depth
   assign pos = AW'(i_ff) + AW'(nin) * AW'(u_ff) + AW'(nin) * AW'(nin) * AW'(v_ff);
   assign emit_addr  = {ez_ff, ey_ff, ex_ff};
   assign mask_raddr = (state_ff == tbt_pkg::ST_EMIT) ? k_ff : pos;
   assign buf0_raddr = (state_ff == tbt_pkg::ST_EMIT) ? emit_addr : {v_ff, i_ff, u_ff};
   assign buf1_raddr = (state_ff == tbt_pkg::ST_EMIT) ? emit_addr : {i_ff, v_ff, u_ff};

   tbt_ram #(.WIDTH(tbt_pkg::VALUE_W), .DEPTH(tbt_pkg::GRID_DEPTH)) u_elem_ram (
      .clock (clock),
      .we    (accept && req_op == tbt_pkg::OP_VALUE),
      .waddr (req_index),
      .wdata (req_value),
      .raddr (pos),
      .rdata (elem_rd)
   );

   tbt_ram #(.WIDTH(1), .DEPTH(tbt_pkg::GRID_DEPTH)) u_mask_ram (
      .clock (clock),
      .we    (accept && req_op == tbt_pkg::OP_MASK),
      .waddr (req_index),
      .wdata (req_mask_bit),
      .raddr (mask_raddr),
      .rdata (mask_rd)
   );

   // ping-pong line buffers, x stride 1, y stride 4, z stride 16
   tbt_ram #(.WIDTH(ACCW), .DEPTH(tbt_pkg::GRID_DEPTH)) u_buf0_ram (
      .clock (clock),
      .we    (tag_done.wr && !tag_done.to_buf1),
      .waddr (tag_done.addr),
      .wdata (mac_sum),
      .raddr (buf0_raddr),
      .rdata (buf0_rd)
   );

   tbt_ram #(.WIDTH(ACCW), .DEPTH(tbt_pkg::GRID_DEPTH)) u_buf1_ram (
      .clock (clock),
      .we    (tag_done.wr && tag_done.to_buf1),
      .waddr (tag_done.addr),
      .wdata (mac_sum),
      .raddr (buf1_raddr),
      .rdata (buf1_rd)
   );

   // ---------------- issue into the mac ----------------
   logic                   issue;
   logic [CW-1:0]          o_cur;
   logic [5:0]             kw;
   logic signed [tbt_pkg::COEF_W-1:0] weight;
   logic signed [ACCW-1:0] src, acc_sel, ring_tail;
   logic [AW-1:0]          dst_addr;

   assign issue = (state_ff == tbt_pkg::ST_RUN) && (slot_ff != '0)
                && (slot_ff <= SLOT_W'(AX));
   assign o_cur = CW'(slot_ff - 1'b1);

   // transposed basis when restricting
   assign kw = restr ? (6'(i_ff) + 6'(q_cl) * 6'(o_cur))
                     : (6'(o_cur) + 6'(q_cl) * 6'(i_ff));
   assign weight = (7'(kw) < 7'(BASIS_DEPTH)) ? basis_ff[BASIS_W'(kw)] : '0;

   always_comb begin
      case (pass_ff)
         tbt_pkg::PASS_X: begin
            // input mask applies before the restriction
            if (restr && !mask_rd) src = '0;
            else src = ACCW'($signed(elem_rd));
            dst_addr = {v_ff, u_ff, o_cur};
         end
         tbt_pkg::PASS_Y: begin
            src      = buf0_rd;
            dst_addr = {v_ff, o_cur, u_ff};
         end
         default: begin
            src      = buf1_rd;
            dst_addr = {o_cur, v_ff, u_ff};
         end
      endcase
   end

   // first input index starts a fresh sum
   assign acc_sel = (i_ff == '0) ? '0 : ring_tail;

   assign tag_issue.valid   = issue;
   assign tag_issue.wr      = issue && (i_ff == i_lim) && ({1'b0, o_cur} < nout);
   assign tag_issue.to_buf1 = (pass_ff == tbt_pkg::PASS_Y);
   assign tag_issue.addr    = dst_addr;

   tbt_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag_issue),
      .acc_in  (acc_sel),
      .a_in    (src),
      .c_in    (weight),
      .tag_out (tag_done),
      .sum_out (mac_sum)
   );

   // ring of accumulator cells closing the loop back to the mac
   logic signed [ACCW-1:0] ring_q [NCELL];

   for (genvar g = 0; g < NCELL; g++) begin : g_ring
      if (g == 0) begin : g_head
         tbt_cell u_cell (.clock(clock), .acc_in(mac_sum), .acc_out(ring_q[g]));
      end else begin : g_body
         tbt_cell u_cell (.clock(clock), .acc_in(ring_q[g-1]), .acc_out(ring_q[g]));
      end
   end

   assign ring_tail = ring_q[NCELL-1];

   // ---------------- result emission ----------------
   logic                   em1_valid_ff, em1_last_ff;
   logic [AW-1:0]          em1_k_ff;
   logic signed [ACCW-1:0] res_sel;
   logic                   rsp_valid_ff, rsp_last_ff;
   logic [AW-1:0]          rsp_index_ff;
   logic signed [tbt_pkg::VALUE_W-1:0] rsp_value_ff;

   assign res_sel = three ? buf0_rd : buf1_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         em1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         em1_valid_ff <= (state_ff == tbt_pkg::ST_EMIT);
         rsp_valid_ff <= em1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      em1_k_ff     <= k_ff;
      em1_last_ff  <= em_last;
      rsp_index_ff <= em1_k_ff;
      rsp_last_ff  <= em1_last_ff;
      // output mask applies after prolongation
      if (!restr && !mask_rd) rsp_value_ff <= '0;
      else rsp_value_ff <= tbt_pkg::sat_out(res_sel);
   end

   assign busy          = (state_ff != tbt_pkg::ST_IDLE) || em1_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

   // ---------------- checks ----------------
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |=> !rsp_valid)
      else $error("result after the last of a run");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |=> rsp_valid)
      else $error("gap inside a result run");

   a_write_in_run: assert property (@(posedge clock) disable iff (reset)
      tag_done.wr |-> state_ff == tbt_pkg::ST_RUN)
      else $error("line buffer written outside a transform");

endmodule
